// ===== hdl/mccs_pkg.sv =====
// Shared types, register and cause codes, and the Q16 filter function.
package mccs_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_ALPHA      = 3'd0;
    localparam logic [2:0] REG_RAISE_MRG  = 3'd1;
    localparam logic [2:0] REG_LOWER_MRG  = 3'd2;
    localparam logic [2:0] REG_LIMIT_UP   = 3'd3;
    localparam logic [2:0] REG_LIMIT_DOWN = 3'd4;
    localparam logic [2:0] REG_MOVE_THR   = 3'd5;
    localparam logic [2:0] REG_DYN_EN     = 3'd6;

    // Trip causes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_LOAD = 2'd1;
    localparam logic [1:0] CAUSE_SUM  = 2'd2;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    typedef struct packed {
        logic [16:0] alpha;
        logic [14:0] raise_margin;
        logic [14:0] lower_margin;
        logic [15:0] limit_up;
        logic [15:0] limit_down;
        logic [15:0] move_thr;
        logic        dyn_en;
    } cfg_t;

    // y + floor(a * (x - y) / 65536), same as the two-term Q16 blend
    function automatic logic [15:0] smooth(input logic [16:0] a_in,
                                           input logic [15:0] x,
                                           input logic [15:0] y);
        logic [16:0]        a;
        logic signed [16:0] diff;
        logic signed [34:0] prod;
        logic signed [34:0] sum;
        a    = (a_in > ALPHA_ONE) ? ALPHA_ONE : a_in;
        diff = $signed({1'b0, x}) - $signed({1'b0, y});
        prod = $signed({1'b0, a}) * diff;
        sum  = $signed({19'd0, y}) + (prod >>> 16);
        return sum[15:0];
    endfunction

endpackage

// ===== hdl/motor_current_collision_supervisor.sv =====
// Top level: motor current collision supervisor with shared window ring.
//
// One input word per supervision tick carries four motor currents, the
// raise flag, the per-motor up mask and a restart flag (s_valid/s_ready).
// One result word per tick leaves on m_valid/m_ready: trip, cause, moving
// mask, calibrated flag and the summed excess current.
// Configuration registers are written on cfg_valid/cfg_ready (always ready)
// by index; write them only while no tick is in flight.
// An input word is held in a buffer register, so a new word is taken while
// the previous one is processed. Processing of a word has a start step, then
// one ring read per motor issued on successive cycles into a five-step
// pipeline (read, filter, sum, divide estimate, correct/check), then a final
// step for the summed check. The single port pair of the window ring memory
// sets the one-motor-per-cycle pace.
// If m_ready stays low the finished word waits in the output register and
// the next word stops at its last cycle until the output is taken.
// Reset returns all filters, averages, calibration and the register file to
// their defaults; the ring needs no clearing pass, since per-motor wrap flags
// mark which entries hold data since the last trip or restart.
module motor_current_collision_supervisor import mccs_pkg::*; #(
    parameter int MOTORS      = 4,
    parameter int WINDOW      = 200,
    parameter int SKIP_TICKS  = 100,
    parameter int CALIB_TICKS = 350
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_current_m0,
    input  logic [15:0] s_current_m1,
    input  logic [15:0] s_current_m2,
    input  logic [15:0] s_current_m3,
    input  logic        s_raising,
    input  logic [3:0]  s_up_mask,
    input  logic        s_restart,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_trip,
    output logic [1:0]  m_trip_cause,
    output logic [3:0]  m_moving_mask,
    output logic        m_calibrated,
    output logic [17:0] m_excess_sum,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int MIW   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int PW    = $clog2(WINDOW);
    localparam int AW    = MIW + PW;
    localparam int SUMW  = $clog2(WINDOW * 65535 + 1);
    localparam int SKW   = $clog2(SKIP_TICKS + 2);
    localparam int CCW   = $clog2(CALIB_TICKS + 2);
    localparam int EXW   = $clog2(MOTORS * 65535 + 1);
    localparam int LAST  = MOTORS + 5;
    localparam int PHW   = $clog2(LAST + 1);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WINDOW);

    cfg_t cfg;

    // configuration registers
    assign cfg_ready = 1'b1;

    mccs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // input buffer
    logic        in_full_reg;
    logic [15:0] in_cur_reg [4];
    logic        in_raising_reg;
    logic [3:0]  in_up_reg;
    logic        in_restart_reg;

    // working copy of the word under processing
    logic [15:0] wk_cur_reg [4];
    logic        wk_raising_reg;
    logic [3:0]  wk_up_reg;

    // sequencer
    logic            busy_reg;
    logic [PHW-1:0]  phase_reg;
    logic            start;
    logic            issue;
    logic            final_fire;
    logic            out_free;
    logic [MIW-1:0]  issue_m;

    // per-motor state
    logic [15:0]     move_filter_reg [MOTORS];
    logic            moving_reg      [MOTORS];
    logic [15:0]     load_filter_reg [MOTORS];
    logic [SUMW-1:0] window_sum_reg  [MOTORS];
    logic [15:0]     window_avg_reg  [MOTORS];
    logic [PW-1:0]   ring_pos_reg    [MOTORS];
    logic            wrapped_reg     [MOTORS];
    logic [SKW-1:0]  skip_count_reg  [MOTORS];
    logic [CCW-1:0]  calib_count_reg [MOTORS];
    logic [15:0]     calib_peak_reg  [MOTORS];
    logic [15:0]     baseline_reg    [MOTORS];
    logic            active_reg;
    logic            trip_flag_reg;

    // pipeline registers
    logic            s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;
    logic [MIW-1:0]  s1_m_reg, s2_m_reg, s3_m_reg, s4_m_reg;
    logic            s1_filt_reg, s2_filt_reg, s3_filt_reg, s4_filt_reg;
    logic [PW-1:0]   s1_p_reg, s2_p_reg;
    logic            s1_old_ok_reg;
    logic [15:0]     s1_x_reg;
    logic [15:0]     s2_f_reg, s3_f_reg, s4_f_reg;
    logic [15:0]     s2_old_reg;
    logic [15:0]     s2_avg_reg, s3_avg_reg, s4_avg_reg;
    logic [SUMW-1:0] s3_sum_reg, s4_sum_reg;
    logic [15:0]     s4_q_reg;

    // output register
    logic        out_valid_reg;
    logic        out_trip_reg;
    logic [1:0]  out_cause_reg;
    logic [3:0]  out_moving_reg;
    logic        out_calib_reg;
    logic [17:0] out_excess_reg;

    // ring memory ports
    logic [15:0]   ram_rdata;
    logic [AW-1:0] ram_raddr;

    assign s_ready    = !in_full_reg;
    assign start      = in_full_reg && !busy_reg;
    assign out_free   = !out_valid_reg || m_ready;
    assign issue      = busy_reg && (phase_reg >= PHW'(1)) && (phase_reg <= PHW'(MOTORS));
    assign final_fire = busy_reg && (phase_reg == PHW'(LAST)) && out_free;
    assign issue_m    = MIW'(phase_reg - PHW'(1));

    // input buffer and working copy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_full_reg <= 1'b1;
        end else if (start) begin
            in_full_reg <= 1'b0;
        end
        if (s_valid && s_ready) begin
            in_cur_reg[0]  <= s_current_m0;
            in_cur_reg[1]  <= s_current_m1;
            in_cur_reg[2]  <= s_current_m2;
            in_cur_reg[3]  <= s_current_m3;
            in_raising_reg <= s_raising;
            in_up_reg      <= s_up_mask;
            in_restart_reg <= s_restart;
        end
        if (start) begin
            wk_cur_reg     <= in_cur_reg;
            wk_raising_reg <= in_raising_reg;
            wk_up_reg      <= in_up_reg;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            phase_reg <= PHW'(1);
        end else if (busy_reg) begin
            if (phase_reg == PHW'(LAST)) begin
                if (out_free) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                phase_reg <= phase_reg + PHW'(1);
            end
        end
    end

    // current, movement filter, skip state and ring position of the issued motor (extra motors read zero)
    logic [15:0] issue_x;
    logic [15:0] issue_mvf;
    logic        issue_skip;
    logic [PW-1:0] issue_p;

    always_comb begin
        issue_x = 16'd0;
        for (int i = 0; i < MOTORS; i++) begin
            if (i < 4 && issue_m == MIW'(i)) begin
                issue_x = wk_cur_reg[i % 4];
            end
        end
        issue_mvf  = smooth(cfg.alpha, issue_x, move_filter_reg[issue_m]);
        issue_skip = skip_count_reg[issue_m] < SKW'(SKIP_TICKS);
        issue_p    = ring_pos_reg[issue_m];
        ram_raddr  = {issue_m, issue_p};
    end

    // filter step
    logic [15:0] f_old;
    logic [15:0] f_lf;
    logic [15:0] f_new;

    always_comb begin
        f_old = s1_old_ok_reg ? ram_rdata : 16'd0;
        f_lf  = load_filter_reg[s1_m_reg];
        f_new = s1_filt_reg ? smooth(cfg.alpha, s1_x_reg, f_lf) : f_lf;
    end

    // window sum step
    logic [SUMW-1:0] sum_new;
    assign sum_new = window_sum_reg[s2_m_reg] - SUMW'(s2_old_reg) + SUMW'(s2_f_reg);

    // divide estimate: floor(sum * RECIP / 2^32) is the quotient or one less
    logic [SUMW+31:0] q_prod;
    assign q_prod = SUMW'(s3_sum_reg) * RECIP;

    // correction, load limit check and calibration inputs
    logic [SUMW-1:0] a_rem;
    logic [15:0]     a_q;
    logic [15:0]     a_avg;
    logic [15:0]     a_limit;
    logic            a_up;
    logic            a_trip;
    logic            a_cal_step;
    logic            a_cal_done;

    always_comb begin
        a_rem = s4_sum_reg - SUMW'(s4_q_reg) * SUMW'(WINDOW);
        a_q   = (a_rem >= SUMW'(WINDOW)) ? s4_q_reg + 16'd1 : s4_q_reg;
        a_avg = s4_filt_reg ? a_q : s4_avg_reg;
        a_up  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (i < MOTORS && s4_m_reg == MIW'(i)) begin
                a_up = wk_up_reg[i];
            end
        end
        a_limit    = a_up ? cfg.limit_up : cfg.limit_down;
        a_trip     = s4_v_reg && !trip_flag_reg && (s4_f_reg > a_limit);
        a_cal_step = s4_v_reg && !trip_flag_reg && !a_trip && cfg.dyn_en && !active_reg;
        a_cal_done = calib_count_reg[s4_m_reg] > CCW'(CALIB_TICKS);
    end

    // summed excess check and result
    logic [EXW-1:0] excess;
    logic [1:0]     fin_cause;
    logic           clr;
    logic [3:0]     moving_mask;

    always_comb begin
        excess = '0;
        for (int i = 0; i < MOTORS; i++) begin
            if (window_avg_reg[i] > baseline_reg[i]) begin
                excess = excess + EXW'(window_avg_reg[i] - baseline_reg[i]);
            end
        end
        if (trip_flag_reg || !active_reg) begin
            excess = '0;
        end
        if (trip_flag_reg) begin
            fin_cause = CAUSE_LOAD;
        end else if (active_reg && excess > EXW'(wk_raising_reg ? cfg.raise_margin
                                                               : cfg.lower_margin)) begin
            fin_cause = CAUSE_SUM;
        end else begin
            fin_cause = CAUSE_NONE;
        end
        moving_mask = 4'd0;
        for (int i = 0; i < 4; i++) begin
            if (i < MOTORS) begin
                moving_mask[i] = moving_reg[i % MOTORS];
            end
        end
        clr = (start && in_restart_reg) || (final_fire && fin_cause != CAUSE_NONE);
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
        s1_m_reg      <= issue_m;
        s1_filt_reg   <= !issue_skip;
        s1_p_reg      <= issue_p;
        s1_old_ok_reg <= wrapped_reg[issue_m];
        s1_x_reg      <= issue_x;
        s2_m_reg      <= s1_m_reg;
        s2_filt_reg   <= s1_filt_reg;
        s2_p_reg      <= s1_p_reg;
        s2_f_reg      <= f_new;
        s2_old_reg    <= f_old;
        s2_avg_reg    <= window_avg_reg[s1_m_reg];
        s3_m_reg      <= s2_m_reg;
        s3_filt_reg   <= s2_filt_reg;
        s3_f_reg      <= s2_f_reg;
        s3_avg_reg    <= s2_avg_reg;
        s3_sum_reg    <= s2_filt_reg ? sum_new : window_sum_reg[s2_m_reg];
        s4_m_reg      <= s3_m_reg;
        s4_filt_reg   <= s3_filt_reg;
        s4_f_reg      <= s3_f_reg;
        s4_avg_reg    <= s3_avg_reg;
        s4_sum_reg    <= s3_sum_reg;
        s4_q_reg      <= q_prod[47:32];
    end

    // per-motor supervision state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MOTORS; i++) begin
                move_filter_reg[i] <= 16'd0;
                moving_reg[i]      <= 1'b0;
                load_filter_reg[i] <= 16'd0;
                window_sum_reg[i]  <= '0;
                window_avg_reg[i]  <= 16'd0;
                ring_pos_reg[i]    <= '0;
                wrapped_reg[i]     <= 1'b0;
                skip_count_reg[i]  <= '0;
                calib_count_reg[i] <= '0;
                calib_peak_reg[i]  <= 16'd0;
                baseline_reg[i]    <= 16'd0;
            end
            active_reg    <= 1'b0;
            trip_flag_reg <= 1'b0;
        end else begin
            if (start) begin
                trip_flag_reg <= 1'b0;
            end
            // issue: movement filter, skip count, ring position
            if (issue) begin
                move_filter_reg[issue_m] <= issue_mvf;
                moving_reg[issue_m]      <= issue_mvf > cfg.move_thr;
                if (issue_skip) begin
                    skip_count_reg[issue_m] <= skip_count_reg[issue_m] + SKW'(1);
                end else if (issue_p == PW'(WINDOW - 1)) begin
                    ring_pos_reg[issue_m] <= '0;
                    wrapped_reg[issue_m]  <= 1'b1;
                end else begin
                    ring_pos_reg[issue_m] <= issue_p + PW'(1);
                end
            end
            // filter
            if (s1_v_reg && s1_filt_reg) begin
                load_filter_reg[s1_m_reg] <= f_new;
            end
            // window sum
            if (s2_v_reg && s2_filt_reg) begin
                window_sum_reg[s2_m_reg] <= sum_new;
            end
            // average, load check, calibration
            if (s4_v_reg && !trip_flag_reg) begin
                window_avg_reg[s4_m_reg] <= a_avg;
            end
            if (a_trip) begin
                trip_flag_reg <= 1'b1;
            end
            if (a_cal_step) begin
                if (!a_cal_done) begin
                    if (a_avg > calib_peak_reg[s4_m_reg]) begin
                        calib_peak_reg[s4_m_reg] <= a_avg;
                    end
                    calib_count_reg[s4_m_reg] <= calib_count_reg[s4_m_reg] + CCW'(1);
                end else begin
                    for (int i = 0; i < MOTORS; i++) begin
                        baseline_reg[i]    <= calib_peak_reg[i];
                        calib_peak_reg[i]  <= 16'd0;
                        calib_count_reg[i] <= '0;
                    end
                    active_reg <= 1'b1;
                end
            end
            // trip or restart clears everything but the movement filters, moving flags and trip flag
            if (clr) begin
                for (int i = 0; i < MOTORS; i++) begin
                    load_filter_reg[i] <= 16'd0;
                    window_sum_reg[i]  <= '0;
                    window_avg_reg[i]  <= 16'd0;
                    ring_pos_reg[i]    <= '0;
                    wrapped_reg[i]     <= 1'b0;
                    skip_count_reg[i]  <= '0;
                    calib_count_reg[i] <= '0;
                    calib_peak_reg[i]  <= 16'd0;
                    baseline_reg[i]    <= 16'd0;
                end
                active_reg <= 1'b0;
            end
        end
    end

    // window ring
    mccs_ring_ram #(.AW(AW)) u_ring (
        .aclk  (aclk),
        .we    (s2_v_reg && s2_filt_reg),
        .waddr ({s2_m_reg, s2_p_reg}),
        .wdata (s2_f_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (final_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (final_fire) begin
            out_trip_reg   <= fin_cause != CAUSE_NONE;
            out_cause_reg  <= fin_cause;
            out_moving_reg <= moving_mask;
            out_calib_reg  <= active_reg && fin_cause == CAUSE_NONE;
            out_excess_reg <= 18'(excess);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_trip        = out_trip_reg;
    assign m_trip_cause  = out_cause_reg;
    assign m_moving_mask = out_moving_reg;
    assign m_calibrated  = out_calib_reg;
    assign m_excess_sum  = out_excess_reg;

    // trip flag and cause agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_trip == (m_trip_cause != CAUSE_NONE)))
        else $error("trip and cause disagree");

    // a tripped result never reports calibration
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trip) |-> !m_calibrated)
        else $error("calibrated set on trip");

    // a max load trip reports no summed excess
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_trip_cause == CAUSE_LOAD) |-> (m_excess_sum == 18'd0))
        else $error("excess on load trip");

    // the sequencer goes idle after a word's final step
    assert property (@(posedge aclk) disable iff (!aresetn)
        final_fire |=> !busy_reg)
        else $error("sequencer did not finish");

endmodule

// ===== hdl/mccs_cfg_regs.sv =====
// Configuration register file of the collision supervisor.
module mccs_cfg_regs import mccs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [16:0] wr_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha        <= 17'd3277;
            cfg_reg.raise_margin <= 15'd0;
            cfg_reg.lower_margin <= 15'd0;
            cfg_reg.limit_up     <= 16'd3000;
            cfg_reg.limit_down   <= 16'd2500;
            cfg_reg.move_thr     <= 16'd80;
            cfg_reg.dyn_en       <= 1'b1;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_ALPHA:      cfg_reg.alpha        <= wr_data;
                REG_RAISE_MRG:  cfg_reg.raise_margin <= wr_data[14:0];
                REG_LOWER_MRG:  cfg_reg.lower_margin <= wr_data[14:0];
                REG_LIMIT_UP:   cfg_reg.limit_up     <= wr_data[15:0];
                REG_LIMIT_DOWN: cfg_reg.limit_down   <= wr_data[15:0];
                REG_MOVE_THR:   cfg_reg.move_thr     <= wr_data[15:0];
                REG_DYN_EN:     cfg_reg.dyn_en       <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/mccs_ring_ram.sv =====
// Window ring memory: one write port, one registered read port.
module mccs_ring_ram #(
    parameter int AW = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [1<<AW];
    logic [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
